// File: src/ckvt_pkg.sv
// Shared types and constants for the compacting key/value table.
// No dependencies; imported by every other module of the block.
`timescale 1ns / 1ps

package ckvt_pkg;

  localparam int unsigned EntriesDef   = 64;
  localparam int unsigned ValueBitsDef = 32;

  localparam int unsigned KeyBits   = 32;
  localparam int unsigned DataBits  = 32;
  localparam int unsigned CountBits = 7;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2
  } ckvt_op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_DUP     = 2'd2,
    ST_MISSING = 2'd3
  } ckvt_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_APPEND,
    S_DONE
  } ckvt_state_e;

  typedef struct packed {
    logic        [1:0]          operation;
    logic signed [KeyBits-1:0]  key;
    logic        [DataBits-1:0] value;
  } ckvt_req_t;

  typedef struct packed {
    ckvt_status_e               status;
    logic        [DataBits-1:0] found_value;
    logic       [CountBits-1:0] entry_count;
  } ckvt_rsp_t;

endpackage

// File: src/ckvt_mem.sv
// Entry storage: one key plus one value per slot, one write and one read port.
// Read data is registered. Depends on ckvt_pkg.
`timescale 1ns / 1ps

module ckvt_mem
  import ckvt_pkg::*;
#(
  parameter int unsigned ENTRIES    = EntriesDef,
  parameter int unsigned VALUE_BITS = ValueBitsDef,
  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned DW = KeyBits + VALUE_BITS
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem_q [ENTRIES];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: src/ckvt_ctrl.sv
// Sequencer: linear key search with one shared key comparator, then append,
// shift-down on remove, or value readout. Depends on ckvt_pkg.
`timescale 1ns / 1ps

module ckvt_ctrl
  import ckvt_pkg::*;
#(
  parameter int unsigned ENTRIES    = EntriesDef,
  parameter int unsigned VALUE_BITS = ValueBitsDef,
  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int unsigned DW = KeyBits + VALUE_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  ckvt_req_t     in_req_i,
  output logic          in_stall_o,
  output logic          res_valid_o,
  output ckvt_rsp_t     res_o,
  input  logic          res_ready_i,
  output logic          wr_en_o,
  output logic [AW-1:0] wr_addr_o,
  output logic [DW-1:0] wr_data_o,
  output logic          rd_en_o,
  output logic [AW-1:0] rd_addr_o,
  input  logic [DW-1:0] rd_data_i
);

  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned IW = CW + 1;

  ckvt_state_e          state_q, state_d;
  ckvt_req_t            req_q, req_d;
  logic        [AW-1:0] idx_q, idx_d;
  logic        [CW-1:0] count_q, count_d;
  ckvt_status_e         status_q, status_d;
  logic  [DataBits-1:0] found_q, found_d;

  logic        [IW-1:0] idx_p1, idx_p2, count_ext;
  logic [KeyBits-1:0]    rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic                  key_hit, more_p1, more_p2, op_known;

  assign idx_p1    = IW'(idx_q) + IW'(1);
  assign idx_p2    = IW'(idx_q) + IW'(2);
  assign count_ext = IW'(count_q);
  assign more_p1   = idx_p1 < count_ext;
  assign more_p2   = idx_p2 < count_ext;

  assign rd_key  = rd_data_i[DW-1 -: KeyBits];
  assign rd_val  = rd_data_i[VALUE_BITS-1:0];
  // the shared comparator
  assign key_hit = (rd_key == req_q.key);

  assign op_known = (in_req_i.operation == OP_ADD) ||
                    (in_req_i.operation == OP_REMOVE) ||
                    (in_req_i.operation == OP_LOOKUP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    found_q  <= found_d;
  end

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    idx_d     = idx_q;
    count_d   = count_q;
    status_d  = status_q;
    found_d   = found_q;
    wr_en_o   = 1'b0;
    wr_addr_o = idx_q;
    wr_data_o = rd_data_i;
    rd_en_o   = 1'b0;
    rd_addr_o = idx_p1[AW-1:0];
    res_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d    = in_req_i;
          idx_d    = '0;
          found_d  = '0;
          status_d = ST_OK;
          priority if (!op_known) begin
            state_d = S_DONE;
          end else if (in_req_i.operation == OP_ADD && count_q >= CW'(ENTRIES)) begin
            status_d = ST_FULL;
            state_d  = S_DONE;
          end else if (count_q == '0) begin
            if (in_req_i.operation == OP_ADD) begin
              state_d = S_APPEND;
            end else begin
              status_d = ST_MISSING;
              state_d  = S_DONE;
            end
          end else begin
            rd_en_o   = 1'b1;
            rd_addr_o = '0;
            state_d   = S_SEARCH;
          end
        end
      end

      // read data holds slot idx_q; slot idx_q+1 is fetched alongside
      S_SEARCH: begin
        if (key_hit) begin
          unique case (req_q.operation)
            OP_ADD: begin
              status_d = ST_DUP;
              state_d  = S_DONE;
            end
            OP_LOOKUP: begin
              found_d = DataBits'(64'(rd_val));
              state_d = S_DONE;
            end
            OP_REMOVE: begin
              if (more_p1) begin
                rd_en_o = 1'b1;
                state_d = S_SHIFT;
              end else begin
                count_d = count_q - CW'(1);
                state_d = S_DONE;
              end
            end
            default: state_d = S_DONE;
          endcase
        end else if (more_p1) begin
          rd_en_o = 1'b1;
          idx_d   = idx_p1[AW-1:0];
        end else if (req_q.operation == OP_ADD) begin
          state_d = S_APPEND;
        end else begin
          status_d = ST_MISSING;
          state_d  = S_DONE;
        end
      end

      // read data holds slot idx_q+1; move it down to idx_q
      S_SHIFT: begin
        wr_en_o = 1'b1;
        if (more_p2) begin
          rd_en_o   = 1'b1;
          rd_addr_o = idx_p2[AW-1:0];
          idx_d     = idx_p1[AW-1:0];
        end else begin
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end
      end

      S_APPEND: begin
        wr_en_o   = 1'b1;
        wr_addr_o = count_q[AW-1:0];
        wr_data_o = {req_q.key, VALUE_BITS'(64'(req_q.value))};
        count_d   = count_q + CW'(1);
        state_d   = S_DONE;
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign res_o.status      = status_q;
  assign res_o.found_value = found_q;
  assign res_o.entry_count = CountBits'(count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(ENTRIES))
    else $error("entry count above table size");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> (state_q == S_SHIFT || state_q == S_APPEND))
    else $error("table write outside shift or append");

  a_count_moves_late: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> state_q == S_DONE)
    else $error("entry count changed before result");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q != S_IDLE)
    else $error("request taken but sequencer stayed idle");

endmodule

// File: src/compacting_key_value_table.sv
// Compacting key/value table: up to ENTRIES unique keys in insertion order.
// Requests scan the stored slots in order (all of them, or up to the
// matching key); an add then appends the new entry, a remove moves every
// later entry down one slot. The single read port reads one slot per cycle.
// The next request is taken only after the result enters the output register.
// Reset (async, low) empties the table; slot contents need no clearing.
`timescale 1ns / 1ps

module compacting_key_value_table
  import ckvt_pkg::*;
#(
  parameter int unsigned ENTRIES    = EntriesDef,
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  ckvt_req_t in_req_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ckvt_rsp_t out_rsp_o
);

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned DW = KeyBits + VALUE_BITS;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [DW-1:0] wr_data, rd_data;
  logic          res_valid, res_ready;
  ckvt_rsp_t     res;

  logic      out_valid_q;
  ckvt_rsp_t out_rsp_q;

  ckvt_ctrl #(
    .ENTRIES   (ENTRIES),
    .VALUE_BITS(VALUE_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_req_i   (in_req_i),
    .in_stall_o (in_stall_o),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_ready_i(res_ready),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data)
  );

  ckvt_mem #(
    .ENTRIES   (ENTRIES),
    .VALUE_BITS(VALUE_BITS)
  ) u_mem (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_rsp_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule
